FILE: hdl/tree_lca_binary_lifting_top_defines.svh
// Assertion helpers for the binary lifting engine.
`ifndef TREE_LCA_BINARY_LIFTING_TOP_DEFINES_SVH
`define TREE_LCA_BINARY_LIFTING_TOP_DEFINES_SVH

// Same-cycle implication.
`define TLCA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TLCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/tlca_pkg.sv
package tlca_pkg;

   localparam int NODE_W      = 10;
   localparam int CNT_W       = 10;
   localparam int DEPTH_W     = 10;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;
   localparam int MODE_W      = 2;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(1023);

   localparam int MAX_NODES_DEF = 1024;
   localparam int LEVELS_DEF    = 10;

   typedef enum logic [MODE_W-1:0] {
      MODE_ATTACH = 2'd0,
      MODE_LIFT   = 2'd1,
      MODE_LCA    = 2'd2
   } mode_type;

   function automatic logic [DEPTH_W-1:0] depth_plus_one(input logic [DEPTH_W-1:0] d);
      return (d == DEPTH_MAX) ? DEPTH_MAX : d + DEPTH_W'(1);
   endfunction

endpackage

FILE: hdl/tree_lca_binary_lifting_top.sv
// Binary lifting ancestor engine. Attach beats (tuser mode 0) must arrive parent first;
// each one writes level 0 of the node's jump row and its depth, then fills each higher
// level by one table read and one write. A lift beat walks the levels from the top down,
// hopping wherever the remaining count allows. An LCA beat reads both depths, levels the
// deeper node like a lift, then, unless both nodes already match, walks all levels with
// two table reads each. Every step is bounded by the single read port of the jump table,
// whose registered data feeds the next address. After reset the depth store is zeroed by
// a pass over all MAX_NODES entries during which req_tready stays low. A result may wait
// in the output register while the next beat is taken.
`include "tree_lca_binary_lifting_top_defines.svh"

module tree_lca_binary_lifting_top #(
   parameter int MAX_NODES = tlca_pkg::MAX_NODES_DEF,
   parameter int LEVELS    = tlca_pkg::LEVELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tlca_pkg::REQ_TDATA_W-1:0]    req_tdata,   // node_a, node_b, lift_count
   input  logic [tlca_pkg::MODE_W-1:0]         req_tuser,   // mode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tlca_pkg::RSP_TDATA_W-1:0]    rsp_tdata    // result_node
);

   localparam int NW = $clog2(MAX_NODES);
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int JUMP_DEPTH = MAX_NODES * (2 ** LW);
   localparam logic [LW-1:0] TOP_LVL = LW'(LEVELS - 1);
   localparam logic [NW-1:0] LAST_IDX = NW'(MAX_NODES - 1);

   localparam int NODE_W  = tlca_pkg::NODE_W;
   localparam int CNT_W   = tlca_pkg::CNT_W;
   localparam int DEPTH_W = tlca_pkg::DEPTH_W;

   typedef enum logic [15:0] {
      S_CLEAR   = 16'h0001,
      S_IDLE    = 16'h0002,
      S_AT_DEP  = 16'h0004,
      S_AT_RD   = 16'h0008,
      S_AT_WR   = 16'h0010,
      S_LF_STEP = 16'h0020,
      S_LF_WAIT = 16'h0040,
      S_LC_DA   = 16'h0080,
      S_LC_DB   = 16'h0100,
      S_LC_CHK  = 16'h0200,
      S_LC_RU   = 16'h0400,
      S_LC_RV   = 16'h0800,
      S_LC_CMP  = 16'h1000,
      S_LC_FIN  = 16'h2000,
      S_LC_LAST = 16'h4000,
      S_OUT     = 16'h8000
   } state_type;

   function automatic logic [NODE_W-1:0] clip_node(input logic [NODE_W-1:0] v);
      return (32'(v) < 32'(MAX_NODES)) ? v : '0;
   endfunction

   // input fields
   logic [NODE_W-1:0]       req_node_a;
   logic [NODE_W-1:0]       req_node_b;
   logic [CNT_W-1:0]        req_lift_count;
   tlca_pkg::mode_type      req_mode;
   logic [NODE_W-1:0]       a_clip;
   logic [NODE_W-1:0]       b_clip;

   assign req_node_a     = req_tdata[NODE_W-1:0];
   assign req_node_b     = req_tdata[2*NODE_W-1:NODE_W];
   assign req_lift_count = req_tdata[2*NODE_W+CNT_W-1:2*NODE_W];
   assign req_mode       = tlca_pkg::mode_type'(req_tuser);
   assign a_clip         = clip_node(req_node_a);
   assign b_clip         = clip_node(req_node_b);

   // state
   state_type               state_ff, state_in;
   tlca_pkg::mode_type      op_ff, op_in;
   logic [NODE_W-1:0]       a_ff, a_in;
   logic [NODE_W-1:0]       b_ff, b_in;
   logic [NODE_W-1:0]       u_ff, u_in;
   logic [NODE_W-1:0]       v_ff, v_in;
   logic [NODE_W-1:0]       pu_ff, pu_in;
   logic [NODE_W-1:0]       res_ff, res_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [DEPTH_W-1:0]      da_ff, da_in;
   logic [LW-1:0]           lvl_ff, lvl_in;
   logic [NW-1:0]           clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]       rsp_data_ff, rsp_data_in;

   // jump table
   logic [NODE_W-1:0]       jump_mem_ff [JUMP_DEPTH];
   logic [NODE_W-1:0]       jump_q_ff;
   logic                    hop_zero_ff;
   logic                    jrd_en;
   logic [NODE_W-1:0]       jrd_node;
   logic [LW-1:0]           jrd_lvl;
   logic                    jwe;
   logic [NODE_W-1:0]       jw_node;
   logic [LW-1:0]           jw_lvl;
   logic [NODE_W-1:0]       jw_data;
   logic [NODE_W-1:0]       hop_h;

   // depth store
   logic [DEPTH_W-1:0]      depth_mem_ff [MAX_NODES];
   logic [DEPTH_W-1:0]      depth_q_ff;
   logic                    drd_en;
   logic [NW-1:0]           drd_idx;
   logic                    dwe;
   logic [NW-1:0]           dw_idx;
   logic [DEPTH_W-1:0]      dw_data;

   // node 0 has no row: its hops read as none
   assign hop_h = hop_zero_ff ? '0 : jump_q_ff;

   always_ff @(posedge clock) begin
      if (jwe) begin
         jump_mem_ff[{NW'(jw_node), jw_lvl}] <= jw_data;
      end
      if (jrd_en) begin
         jump_q_ff   <= jump_mem_ff[{NW'(jrd_node), jrd_lvl}];
         hop_zero_ff <= (jrd_node == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (dwe) begin
         depth_mem_ff[dw_idx] <= dw_data;
      end
      if (drd_en) begin
         depth_q_ff <= depth_mem_ff[drd_idx];
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      pu_in        = pu_ff;
      res_in       = res_ff;
      cnt_in       = cnt_ff;
      da_in        = da_ff;
      lvl_in       = lvl_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      jrd_en       = 1'b0;
      jrd_node     = u_ff;
      jrd_lvl      = lvl_ff;
      jwe          = 1'b0;
      jw_node      = a_ff;
      jw_lvl       = lvl_ff;
      jw_data      = hop_h;
      drd_en       = 1'b0;
      drd_idx      = NW'(a_ff);
      dwe          = 1'b0;
      dw_idx       = NW'(a_ff);
      dw_data      = tlca_pkg::depth_plus_one(depth_q_ff);

      unique case (state_ff)
         S_CLEAR: begin
            dwe     = 1'b1;
            dw_idx  = clr_ff;
            dw_data = '0;
            clr_in  = clr_ff + NW'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in  = req_mode;
               a_in   = a_clip;
               b_in   = b_clip;
               cnt_in = req_lift_count;
               unique case (req_mode)
                  tlca_pkg::MODE_ATTACH: begin
                     if (a_clip == '0) begin
                        res_in   = req_node_a;
                        state_in = S_OUT;
                     end else begin
                        jwe      = 1'b1;
                        jw_node  = a_clip;
                        jw_lvl   = '0;
                        jw_data  = b_clip;
                        drd_en   = 1'b1;
                        drd_idx  = NW'(b_clip);
                        u_in     = b_clip;
                        lvl_in   = LW'(1);
                        state_in = S_AT_DEP;
                     end
                  end
                  tlca_pkg::MODE_LIFT: begin
                     u_in     = a_clip;
                     lvl_in   = TOP_LVL;
                     state_in = S_LF_STEP;
                  end
                  tlca_pkg::MODE_LCA: begin
                     if (a_clip == '0 || b_clip == '0) begin
                        res_in   = '0;
                        state_in = S_OUT;
                     end else begin
                        drd_en   = 1'b1;
                        drd_idx  = NW'(a_clip);
                        state_in = S_LC_DA;
                     end
                  end
                  default: begin
                     res_in   = '0;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_AT_DEP: begin
            dwe = 1'b1;
            if (LEVELS == 1) begin
               res_in   = a_ff;
               state_in = S_OUT;
            end else begin
               state_in = S_AT_RD;
            end
         end
         S_AT_RD: begin
            // level i of the row is level i-1 of the row one level up
            jrd_en   = 1'b1;
            jrd_node = u_ff;
            jrd_lvl  = lvl_ff - LW'(1);
            state_in = S_AT_WR;
         end
         S_AT_WR: begin
            jwe  = 1'b1;
            u_in = hop_h;
            if (lvl_ff == TOP_LVL) begin
               res_in   = a_ff;
               state_in = S_OUT;
            end else begin
               lvl_in   = lvl_ff + LW'(1);
               state_in = S_AT_RD;
            end
         end
         S_LF_STEP: begin
            if (u_ff == '0 || cnt_ff == '0) begin
               if (op_ff == tlca_pkg::MODE_LCA) begin
                  state_in = S_LC_CHK;
               end else begin
                  res_in   = u_ff;
                  state_in = S_OUT;
               end
            end else if ((cnt_ff >> lvl_ff) != '0) begin
               // top level repeats while the count allows
               jrd_en   = 1'b1;
               cnt_in   = cnt_ff - (CNT_W'(1) << lvl_ff);
               state_in = S_LF_WAIT;
            end else begin
               lvl_in = lvl_ff - LW'(1);
            end
         end
         S_LF_WAIT: begin
            u_in     = hop_h;
            state_in = S_LF_STEP;
         end
         S_LC_DA: begin
            da_in    = depth_q_ff;
            drd_en   = 1'b1;
            drd_idx  = NW'(b_ff);
            state_in = S_LC_DB;
         end
         S_LC_DB: begin
            if (da_ff < depth_q_ff) begin
               u_in   = b_ff;
               v_in   = a_ff;
               cnt_in = CNT_W'(depth_q_ff - da_ff);
            end else begin
               u_in   = a_ff;
               v_in   = b_ff;
               cnt_in = CNT_W'(da_ff - depth_q_ff);
            end
            lvl_in   = TOP_LVL;
            state_in = S_LF_STEP;
         end
         S_LC_CHK: begin
            if (u_ff == v_ff) begin
               res_in   = u_ff;
               state_in = S_OUT;
            end else begin
               lvl_in   = TOP_LVL;
               state_in = S_LC_RU;
            end
         end
         S_LC_RU: begin
            jrd_en   = 1'b1;
            state_in = S_LC_RV;
         end
         S_LC_RV: begin
            pu_in    = hop_h;
            jrd_en   = 1'b1;
            jrd_node = v_ff;
            state_in = S_LC_CMP;
         end
         S_LC_CMP: begin
            if (pu_ff != hop_h) begin
               u_in = pu_ff;
               v_in = hop_h;
            end
            if (lvl_ff == '0) begin
               state_in = S_LC_FIN;
            end else begin
               lvl_in   = lvl_ff - LW'(1);
               state_in = S_LC_RU;
            end
         end
         S_LC_FIN: begin
            jrd_en   = 1'b1;
            jrd_lvl  = '0;
            state_in = S_LC_LAST;
         end
         S_LC_LAST: begin
            res_in   = hop_h;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      pu_ff       <= pu_in;
      res_ff      <= res_in;
      cnt_ff      <= cnt_in;
      da_ff       <= da_in;
      lvl_ff      <= lvl_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = tlca_pkg::RSP_TDATA_W'(rsp_data_ff);

   `TLCA_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_tvalid && req_tready, !req_tready, "block still ready after taking a beat")
   `TLCA_ASSERT_SAME(a_no_null_row, clock, reset, jwe, jw_node != '0, "jump row of the null node written")
   `TLCA_ASSERT_NEXT(a_lift_progress, clock, reset, (state_ff == S_LF_STEP) && jrd_en, cnt_ff < $past(cnt_ff), "lift hop did not reduce the count")
   `TLCA_ASSERT_NEXT(a_rsp_load, clock, reset, (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready), rsp_tvalid && (rsp_data_ff == $past(res_ff)), "result not loaded into output register")

endmodule
